>>> design/mwq_pkg.sv
// Package for the morphing wavetable quintic interpolator.
// Holds shared types, constants and the polynomial coefficient function.
// No dependencies.
package mwq_pkg;

  typedef logic [31:0] word32_t;
  typedef logic [5:0][31:0] point_vec_t;

  localparam logic [20:0] InvScale = 21'd699051;
  localparam int unsigned SampleMax = 4095;

  // Coefficient indexes of the fifth-order polynomial.
  localparam logic [2:0] CoefC0 = 3'd0;
  localparam logic [2:0] CoefC1 = 3'd1;
  localparam logic [2:0] CoefC2 = 3'd2;
  localparam logic [2:0] CoefC3 = 3'd3;
  localparam logic [2:0] CoefC4 = 3'd4;
  localparam logic [2:0] CoefC5 = 3'd5;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_MOD   = 10'b00_0000_0010,
    S_READ  = 10'b00_0000_0100,
    S_HINIT = 10'b00_0000_1000,
    S_HMUL  = 10'b00_0001_0000,
    S_HADD  = 10'b00_0010_0000,
    S_FMUL1 = 10'b00_0100_0000,
    S_FMUL2 = 10'b00_1000_0000,
    S_FADD  = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  // Polynomial coefficient from the six blended points; all sums wrap at 32 bits.
  function automatic word32_t poly_coef(input logic [2:0] k, input point_vec_t v);
    word32_t r;
    r = v[2];
    unique case (k)
      CoefC5: r = (v[3] - v[2]) * 32'd50 + (v[1] - v[4]) * 32'd25 + (v[5] - v[0]) * 32'd5;
      CoefC4: r = v[2] * 32'd126 - v[3] * 32'd124 + v[4] * 32'd61 - v[1] * 32'd64
                  - v[5] * 32'd12 + v[0] * 32'd13;
      CoefC3: r = v[3] * 32'd66 - v[2] * 32'd70 - v[4] * 32'd33 + v[1] * 32'd39
                  + v[5] * 32'd7 - v[0] * 32'd9;
      CoefC2: r = (v[3] + v[1]) * 32'd16 - v[0] - v[2] * 32'd30 - v[4];
      CoefC1: r = (v[3] - v[1]) * 32'd16 + (v[0] - v[4]) * 32'd2;
      CoefC0: r = v[2];
      default: r = v[2];
    endcase
    return r;
  endfunction

endpackage

>>> design/mwq_in_if.sv
// Request channel interface of the wavetable interpolator.
// Carries valid, ready and the request payload; no dependencies.
interface mwq_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [3:0]  wave_index;
  logic [9:0]  word_index;
  logic [15:0] word_value;
  logic [24:0] phase;
  logic [11:0] morph;

  modport source (output valid, op, wave_index, word_index, word_value, phase, morph,
                  input ready);
  modport sink (input valid, op, wave_index, word_index, word_value, phase, morph,
                output ready);
endinterface

>>> design/mwq_out_if.sv
// Result channel interface of the wavetable interpolator.
// Carries valid, ready and the sample payload; no dependencies.
interface mwq_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample_out;
  logic        slope_gate;

  modport source (output valid, sample_out, slope_gate, input ready);
  modport sink (input valid, sample_out, slope_gate, output ready);
endinterface

>>> design/morphing_wavetable_quintic_interp.sv
// An accepted sample request first reduces the row position by subtracting ROW_WORDS while it
// is out of range; no subtraction is needed when ROW_WORDS exceeds 511. The row bases are set
// up in that same state. Twelve words then stream from the single table RAM read port while the
// shared multiplier blends each pair. The Horner steps and final scaling then run through that
// same multiplier, and the result is loaded into the output register. That load waits while an
// earlier sample is still held there. No new request is taken until the load is done. A table
// write is taken in the idle state. A finished sample waits in the output register while the
// next request is taken. Words never written read back undefined; table contents are not
// cleared at reset.
module morphing_wavetable_quintic_interp
  import mwq_pkg::*;
#(
  parameter int WAVE_COUNT = 9,
  parameter int ROW_WORDS  = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  mwq_in_if.sink      in_ch,
  mwq_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);
  localparam int DEPTH = WAVE_COUNT * ROW_WORDS;
  localparam int AW = $clog2(DEPTH);
  localparam int TW = $clog2(WAVE_COUNT);
  localparam int PW = ($clog2(ROW_WORDS + 1) > 9) ? $clog2(ROW_WORDS + 1) : 9;
  localparam logic [1:0] CfgShr = 2'd0;
  localparam logic [1:0] CfgShl = 2'd1;

  state_t state_r, state_nxt;

  logic [3:0]        shr_r, shl_r;
  logic [TW-1:0]     tab0_r, tab1_r;
  logic [AW-1:0]     base0_r, base1_r;
  logic [PW-1:0]     pos_r;
  logic [26:0]       f_r;
  logic [15:0]       fr_r;
  logic [3:0]        cnt_r;
  logic [2:0]        k_r;
  logic [15:0]       a_r;
  point_vec_t        v_r;
  word32_t           h_r, coef_r;
  logic              gate_r;
  logic              out_valid_r;
  logic [11:0]       sample_r;

  logic              accept;
  logic              wr_en;
  logic [AW-1:0]     waddr, raddr;
  logic [15:0]       rdata;
  logic signed [31:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [52:0] prod;
  logic [11:0]       tab_raw, rem;
  logic [12:0]       tab_ext;
  logic [TW-1:0]     tab0_c, tab1_c;
  logic signed [31:0] s_shift;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept = in_ch.valid && in_ch.ready;
  assign wr_en = accept && !in_ch.op && (32'(in_ch.wave_index) < 32'(WAVE_COUNT))
                 && (32'(in_ch.word_index) < 32'(ROW_WORDS));
  assign waddr = AW'(32'(in_ch.wave_index) * ROW_WORDS + 32'(in_ch.word_index));
  assign raddr = (cnt_r[0] ? base1_r : base0_r) + AW'(pos_r);

  mwq_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(waddr),
    .wdata(in_ch.word_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Table pair and blend fraction from the morph value.
  always_comb begin
    tab_raw = in_ch.morph >> shr_r;
    rem = in_ch.morph & ~(12'hFFF << shr_r);
    tab_ext = {1'b0, tab_raw};
    if (32'(tab_ext) >= 32'(WAVE_COUNT - 1)) begin
      tab0_c = TW'(WAVE_COUNT - 1);
      tab1_c = TW'(WAVE_COUNT - 1);
    end else begin
      tab0_c = TW'(tab_raw);
      tab1_c = TW'(tab_raw + 12'd1);
    end
  end

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = $signed(h_r);
    mul_b = $signed({5'd0, fr_r});
    unique case (state_r)
      S_READ: begin
        mul_a = $signed({5'd0, f_r});
        mul_b = $signed(21'(signed'({1'b0, rdata}) - signed'({1'b0, a_r})));
      end
      S_FMUL2: begin
        mul_a = $signed(prod[47:16]);
        mul_b = $signed(InvScale);
      end
      default: begin
        mul_a = $signed(h_r);
        mul_b = $signed({5'd0, fr_r});
      end
    endcase
  end

  mwq_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod));

  assign s_shift = $signed(h_r) >>> 3;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && in_ch.op) state_nxt = S_MOD;
      S_MOD:   if (32'(pos_r) < 32'(ROW_WORDS)) state_nxt = S_READ;
      S_READ:  if (cnt_r == 4'd13) state_nxt = S_HINIT;
      S_HINIT: state_nxt = S_HMUL;
      S_HMUL:  state_nxt = S_HADD;
      S_HADD:  state_nxt = (k_r == CoefC1) ? S_FMUL1 : S_HMUL;
      S_FMUL1: state_nxt = S_FMUL2;
      S_FMUL2: state_nxt = S_FADD;
      S_FADD:  state_nxt = S_OUT;
      S_OUT:   if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      shr_r       <= 4'd11;
      shl_r       <= 4'd5;
      gate_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case ({1'b0, cfg_index})
          CfgShr:  shr_r <= cfg_data;
          CfgShl:  shl_r <= cfg_data;
          default: shr_r <= shr_r;
        endcase
      end
      if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
        if (v_r[2] < v_r[3]) begin
          gate_r <= 1'b1;
        end else if (v_r[3] < v_r[2]) begin
          gate_r <= 1'b0;
        end
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          pos_r  <= PW'(in_ch.phase[24:16]);
          fr_r   <= in_ch.phase[15:0];
          tab0_r <= tab0_c;
          tab1_r <= tab1_c;
          f_r    <= 27'({15'd0, rem} << shl_r);
        end
        cnt_r <= 4'd0;
      end
      S_MOD: begin
        if (32'(pos_r) >= 32'(ROW_WORDS)) begin
          pos_r <= PW'(32'(pos_r) - 32'(ROW_WORDS));
        end
        base0_r <= AW'(32'(tab0_r) * ROW_WORDS);
        base1_r <= AW'(32'(tab1_r) * ROW_WORDS);
        cnt_r   <= 4'd0;
      end
      S_READ: begin
        cnt_r <= cnt_r + 4'd1;
        // Step to the next word after both tables have been addressed.
        if (cnt_r[0] && cnt_r < 4'd12) begin
          pos_r <= (32'(pos_r) == 32'(ROW_WORDS - 1)) ? '0 : pos_r + PW'(1);
        end
        // Odd counts carry a word of the lower table and retire the previous blend.
        if (cnt_r[0]) begin
          if (cnt_r <= 4'd11) begin
            a_r <= rdata;
          end
          if (cnt_r >= 4'd3) begin
            v_r[3'((cnt_r - 4'd3) >> 1)] <= {16'd0, a_r} + prod[47:16];
          end
        end
      end
      S_HINIT: begin
        h_r <= poly_coef(CoefC5, v_r);
        k_r <= CoefC4;
      end
      S_HMUL: coef_r <= poly_coef(k_r, v_r);
      S_HADD: begin
        h_r <= coef_r + prod[47:16];
        k_r <= k_r - 3'd1;
      end
      S_FADD: h_r <= v_r[2] + 32'(prod >>> 24);
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          if (s_shift < 0) begin
            sample_r <= 12'd0;
          end else if (s_shift > 32'(SampleMax)) begin
            sample_r <= 12'(SampleMax);
          end else begin
            sample_r <= s_shift[11:0];
          end
        end
      end
      default: cnt_r <= cnt_r;
    endcase
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = sample_r;
  assign out_ch.slope_gate = gate_r;
endmodule

>>> design/mwq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mwq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 9216
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/mwq_mul.sv
// Shared registered signed multiplier, 32 by 21 bits.
// No dependencies.
module mwq_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [20:0] b,
  output logic signed [52:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= 53'(a) * 53'(b);
  end
endmodule
